/* rtl/core/prp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prp_pkg
// Shared types, widths and saturation helpers for the rebound predictor.
// ---------------------------------------------------------------------------
package prp_pkg;

   localparam int COORD_BITS = 11;
   localparam int FRAC_BITS  = 20;
   localparam int SLOPE_W    = 40;
   localparam int ICPT_W     = 48;
   localparam int PT_W       = 24;
   localparam int NUM_W      = 50;
   localparam int DEN_W      = 41;
   localparam int MUL_A_W    = 40;
   localparam int MUL_B_W    = 13;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int BNC_W      = 5;
   localparam int ADDR_W     = 5;

   typedef enum logic [2:0] {
      REG_LEFT_WALL  = 3'd0,
      REG_RIGHT_WALL = 3'd1,
      REG_CENTER     = 3'd2,
      REG_MARGIN     = 3'd3,
      REG_BIAS       = 3'd4,
      REG_LIMIT      = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  left_wall_x;
      logic [COORD_BITS-1:0]  right_wall_x;
      logic [COORD_BITS-1:0]  center_x;
      logic [7:0]             wall_margin;
      logic signed [20:0]     slope_bias;
      logic [3:0]             rebound_limit;
   } cfg_type;

   function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (PT_W - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi[PT_W-1:0];
      if (v < lo) return lo[PT_W-1:0];
      return v[PT_W-1:0];
   endfunction

   function automatic logic signed [SLOPE_W-1:0] sat_slope(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (SLOPE_W - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi[SLOPE_W-1:0];
      if (v < lo) return lo[SLOPE_W-1:0];
      return v[SLOPE_W-1:0];
   endfunction

   function automatic logic signed [ICPT_W-1:0] sat_icpt(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (ICPT_W - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi[ICPT_W-1:0];
      if (v < lo) return lo[ICPT_W-1:0];
      return v[ICPT_W-1:0];
   endfunction

endpackage

/* rtl/core/prp_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prp_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ---------------------------------------------------------------------------
module prp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [prp_pkg::NUM_W-1:0]  num,
   input  logic signed [prp_pkg::DEN_W-1:0]  den,
   output logic                              done,
   output logic signed [prp_pkg::NUM_W-1:0]  quo
);
   import prp_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  q_ff, q_in;
   logic [DEN_W-1:0]  d_ff, d_in;
   logic [DEN_W-1:0]  r_ff, r_in;
   logic              neg_ff, neg_in;
   logic [DEN_W:0]    r_shift;
   logic [DEN_W:0]    r_diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      neg_in  = neg_ff;
      r_shift = {r_ff, q_ff[NUM_W-1]};
      r_diff  = r_shift - {1'b0, d_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         q_in    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         d_in    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         r_in    = '0;
         neg_in  = num[NUM_W-1] ^ den[DEN_W-1];
      end else if (busy_ff) begin
         if (!r_diff[DEN_W]) begin
            r_in = r_diff[DEN_W-1:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = r_shift[DEN_W-1:0];
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

/* rtl/core/prp_csr.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prp_csr
// APB-style register file: walls, centre, margin, slope bias, bounce limit.
// ---------------------------------------------------------------------------
module prp_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [prp_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output prp_pkg::cfg_type             cfg
);
   import prp_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr;

   assign idx    = reg_idx_type'(paddr[4:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_wall_x   <= 11'd0;
         cfg_ff.right_wall_x  <= 11'd2047;
         cfg_ff.center_x      <= 11'd1024;
         cfg_ff.wall_margin   <= 8'd10;
         cfg_ff.slope_bias    <= 21'sd209715;
         cfg_ff.rebound_limit <= 4'd3;
      end else if (wr) begin
         case (idx)
            REG_LEFT_WALL:  cfg_ff.left_wall_x   <= pwdata[COORD_BITS-1:0];
            REG_RIGHT_WALL: cfg_ff.right_wall_x  <= pwdata[COORD_BITS-1:0];
            REG_CENTER:     cfg_ff.center_x      <= pwdata[COORD_BITS-1:0];
            REG_MARGIN:     cfg_ff.wall_margin   <= pwdata[7:0];
            REG_BIAS:       cfg_ff.slope_bias    <= pwdata[20:0];
            REG_LIMIT:      cfg_ff.rebound_limit <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_LEFT_WALL:  prdata = 32'(cfg_ff.left_wall_x);
         REG_RIGHT_WALL: prdata = 32'(cfg_ff.right_wall_x);
         REG_CENTER:     prdata = 32'(cfg_ff.center_x);
         REG_MARGIN:     prdata = 32'(cfg_ff.wall_margin);
         REG_BIAS:       prdata = {11'd0, cfg_ff.slope_bias};
         REG_LIMIT:      prdata = 32'(cfg_ff.rebound_limit);
         default:        prdata = 32'd0;
      endcase
   end

endmodule

/* rtl/core/puck_rebound_predictor.sv */
`timescale 1ns / 1ps
// Flow: each line solve is a pass of the shared bit-serial divider; mode 0
//   fits the line, then solves once plus once more per bounce; mode 1 solves
//   once and adds a multiply when the wall is hit; straight motion or a flat
//   stored line skips the divider.
// Throughput: one item at a time; the next transfer is taken once the result is
//   handed to the output register; the divider and output stalls set the rate.
// Reset: synchronous, active high; clears control and stored line, presets CSRs.
// ---------------------------------------------------------------------------
// puck_rebound_predictor
// Fits a line through two puck points, solves for the crossing of a target
// row and mirrors the line off the inset walls until it lands between them.
// ---------------------------------------------------------------------------
module puck_rebound_predictor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [prp_pkg::COORD_BITS-1:0]       req_first_x,
   input  logic [prp_pkg::COORD_BITS-1:0]       req_first_y,
   input  logic [prp_pkg::COORD_BITS-1:0]       req_second_x,
   input  logic [prp_pkg::COORD_BITS-1:0]       req_second_y,
   input  logic [prp_pkg::COORD_BITS-1:0]       req_line_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [prp_pkg::PT_W-1:0]      rsp_point_x,
   output logic signed [prp_pkg::PT_W-1:0]      rsp_point_y,
   output logic                                 rsp_ok,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [prp_pkg::ADDR_W-1:0]           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import prp_pkg::*;

   // Sequencer states. Each *_DIV state waits on the shared divider.
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_FIT_DIV, S_FIT_MUL, S_FIT_ICPT, S_TX_START, S_TX_DIV,
      S_BNC_MUL, S_BNC_UPD, S_M1_DIV, S_M1_MUL, S_M1_SUM, S_EMIT
   } state_type;

   cfg_type cfg;

   prp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   state_type                   state_ff, state_in;
   logic                        mode_ff;
   logic [COORD_BITS-1:0]       x1_ff, y1_ff, x2_ff, y2_ff, ly_ff;
   logic signed [SLOPE_W-1:0]   slope_ff, slope_in;
   logic signed [ICPT_W-1:0]    icpt_ff, icpt_in;
   logic signed [MUL_B_W-1:0]   wall_ff, wall_in;
   logic signed [NUM_W-1:0]     xq_ff, xq_in;
   logic [BNC_W-1:0]            bnc_ff, bnc_in;
   logic signed [PT_W-1:0]      res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                        res_ok_ff, res_ok_in;
   logic                        rsp_valid_ff;
   logic signed [PT_W-1:0]      rsp_x_ff, rsp_y_ff;
   logic                        rsp_ok_ff;
   logic signed [PROD_W-1:0]    prod_ff;

   // shared multiplier operands
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;

   // divider
   logic                        div_start;
   logic signed [NUM_W-1:0]     div_num;
   logic signed [DEN_W-1:0]     div_den;
   logic                        div_done;
   logic signed [NUM_W-1:0]     div_quo;

   prp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Derived terms
   logic signed [COORD_BITS+1:0] dx, dy;
   logic signed [MUL_B_W-1:0]    left_in, right_in;
   logic signed [SLOPE_W-1:0]    a_int;   // slope truncated toward zero
   logic signed [ICPT_W-1:0]     b_int;   // intercept truncated toward zero
   logic signed [NUM_W-1:0]      ly_fx;
   logic signed [SLOPE_W+1:0]    slope_next;
   logic signed [63:0]           wide_v;
   logic                         out_free;

   assign dx      = $signed({2'b00, x2_ff}) - $signed({2'b00, x1_ff});
   assign dy      = $signed({2'b00, y2_ff}) - $signed({2'b00, y1_ff});
   assign left_in = $signed(MUL_B_W'(cfg.left_wall_x)) + $signed(MUL_B_W'(cfg.wall_margin));
   assign right_in = $signed(MUL_B_W'(cfg.right_wall_x)) - $signed(MUL_B_W'(cfg.wall_margin));
   assign ly_fx   = $signed(NUM_W'(ly_ff)) <<< FRAC_BITS;
   assign a_int   = (slope_ff >>> FRAC_BITS)
                    + ((slope_ff < 0 && slope_ff[FRAC_BITS-1:0] != '0) ?
                       SLOPE_W'(1) : SLOPE_W'(0));
   assign b_int   = (icpt_ff >>> FRAC_BITS)
                    + ((icpt_ff < 0 && icpt_ff[FRAC_BITS-1:0] != '0) ?
                       ICPT_W'(1) : ICPT_W'(0));
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_ok      = rsp_ok_ff;

   always_comb begin
      state_in  = state_ff;
      slope_in  = slope_ff;
      icpt_in   = icpt_ff;
      wall_in   = wall_ff;
      xq_in     = xq_ff;
      bnc_in    = bnc_ff;
      res_x_in  = res_x_ff;
      res_y_in  = res_y_ff;
      res_ok_in = res_ok_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mul_a     = slope_ff;
      mul_b     = wall_ff;
      slope_next = '0;
      wide_v    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (mode_ff) begin
               if (a_int == 0) begin
                  res_x_in  = '0;
                  res_y_in  = '0;
                  res_ok_in = 1'b1;
                  state_in  = S_EMIT;
               end else begin
                  div_start = 1'b1;
                  div_num   = $signed(NUM_W'(ly_ff)) - NUM_W'(b_int);
                  div_den   = DEN_W'(a_int);
                  state_in  = S_M1_DIV;
               end
            end else if (dx == 0 || dy == 0) begin
               // straight vertical or horizontal motion: drop the line
               slope_in  = '0;
               icpt_in   = '0;
               res_x_in  = PT_W'(cfg.center_x);
               res_y_in  = PT_W'(ly_ff);
               res_ok_in = 1'b0;
               state_in  = S_EMIT;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_W'(dy) <<< FRAC_BITS;
               div_den   = DEN_W'(dx);
               bnc_in    = '0;
               state_in  = S_FIT_DIV;
            end
         end
         S_FIT_DIV: begin
            if (div_done) begin
               if (div_quo == 0) begin
                  slope_in  = '0;
                  icpt_in   = '0;
                  res_x_in  = PT_W'(cfg.center_x);
                  res_y_in  = PT_W'(ly_ff);
                  res_ok_in = 1'b0;
                  state_in  = S_EMIT;
               end else begin
                  slope_in = sat_slope(64'(div_quo));
                  state_in = S_FIT_MUL;
               end
            end
         end
         S_FIT_MUL: begin
            mul_b    = $signed(MUL_B_W'(x2_ff));
            state_in = S_FIT_ICPT;
         end
         S_FIT_ICPT: begin
            wide_v   = ($signed(64'(y2_ff)) <<< FRAC_BITS) - 64'(prod_ff);
            icpt_in  = sat_icpt(wide_v);
            state_in = S_TX_START;
         end
         S_TX_START: begin
            div_start = 1'b1;
            div_num   = ly_fx - NUM_W'(icpt_ff);
            div_den   = DEN_W'(slope_ff);
            state_in  = S_TX_DIV;
         end
         S_TX_DIV: begin
            if (div_done) begin
               if (div_quo < NUM_W'(left_in)) begin
                  wall_in  = left_in;
                  xq_in    = '0;      // left bounce
                  state_in = S_BNC_MUL;
               end else if (NUM_W'(right_in) < div_quo) begin
                  wall_in  = right_in;
                  xq_in    = NUM_W'(1); // right bounce
                  state_in = S_BNC_MUL;
               end else begin
                  res_x_in  = sat_pt(64'(div_quo));
                  res_y_in  = PT_W'(ly_ff);
                  res_ok_in = 1'b1;
                  state_in  = S_EMIT;
               end
            end
         end
         S_BNC_MUL: begin
            state_in = S_BNC_UPD;
         end
         S_BNC_UPD: begin
            // mirror off the wall: b += 2*a*wall, a = -a +/- bias
            wide_v  = 64'(icpt_ff) + (64'(prod_ff) <<< 1);
            icpt_in = sat_icpt(wide_v);
            if (xq_ff[0])
               slope_next = -(SLOPE_W+2)'(slope_ff) - (SLOPE_W+2)'(cfg.slope_bias);
            else
               slope_next = -(SLOPE_W+2)'(slope_ff) + (SLOPE_W+2)'(cfg.slope_bias);
            slope_in = sat_slope(64'(slope_next));
            bnc_in   = bnc_ff + BNC_W'(1);
            if (BNC_W'(cfg.rebound_limit) < bnc_in || slope_in == 0) begin
               res_x_in  = PT_W'(cfg.center_x);
               res_y_in  = PT_W'(ly_ff);
               res_ok_in = 1'b0;
               state_in  = S_EMIT;
            end else begin
               state_in = S_TX_START;
            end
         end
         S_M1_DIV: begin
            if (div_done) begin
               xq_in = div_quo;
               if (a_int < 0 && div_quo < $signed(NUM_W'(cfg.left_wall_x))) begin
                  wall_in  = MUL_B_W'(cfg.left_wall_x);
                  state_in = S_M1_MUL;
               end else if (a_int > 0 && $signed(NUM_W'(cfg.right_wall_x)) < div_quo) begin
                  wall_in  = MUL_B_W'(cfg.right_wall_x);
                  state_in = S_M1_MUL;
               end else begin
                  res_x_in  = sat_pt(64'(div_quo));
                  res_y_in  = PT_W'(ly_ff);
                  res_ok_in = 1'b1;
                  state_in  = S_EMIT;
               end
            end
         end
         S_M1_MUL: begin
            mul_a    = a_int;
            state_in = S_M1_SUM;
         end
         S_M1_SUM: begin
            wide_v    = 64'(prod_ff) + 64'(b_int);
            res_x_in  = PT_W'(wall_ff);
            res_y_in  = sat_pt(wide_v);
            res_ok_in = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slope_ff     <= '0;
         icpt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         bnc_ff       <= '0;
      end else begin
         state_ff <= state_in;
         slope_ff <= slope_in;
         icpt_ff  <= icpt_in;
         bnc_ff   <= bnc_in;
         if (state_ff == S_EMIT && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
      if (state_ff == S_IDLE && req_valid) begin
         mode_ff <= req_mode;
         x1_ff   <= req_first_x;
         y1_ff   <= req_first_y;
         x2_ff   <= req_second_x;
         y2_ff   <= req_second_y;
         ly_ff   <= req_line_y;
      end
      if (state_ff == S_EMIT && out_free) begin
         rsp_x_ff  <= res_x_ff;
         rsp_y_ff  <= res_y_ff;
         rsp_ok_ff <= res_ok_ff;
      end
      wall_ff   <= wall_in;
      xq_ff     <= xq_in;
      res_x_ff  <= res_x_in;
      res_y_ff  <= res_y_in;
      res_ok_ff <= res_ok_in;
      prod_ff   <= mul_a * mul_b;
   end

endmodule

/* bench/puck_rebound_predictor_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// puck_rebound_predictor_test
// Self-checking bench for the rebound predictor: directed and random puck
// tracks over several wall/bias settings, each result checked against an
// in-bench fixed point line/bounce model, with random idles on both channels.
// ---------------------------------------------------------------------------
module puck_rebound_predictor_test;
   import prp_pkg::*;

   localparam longint ONE_FX      = 64'sd1 <<< FRAC_BITS;
   localparam int     CYCLE_LIMIT = 20000000;
   localparam int     NUM_PHASES  = 9;
   localparam int     RAND_ITEMS  = 250;   // per random phase

   typedef struct {
      logic                  mode;
      logic [COORD_BITS-1:0] first_x, first_y, second_x, second_y, line_y;
   } track_item_type;

   typedef struct {
      logic signed [PT_W-1:0] point_x, point_y;
      logic                   ok;
   } forecast_type;

   // DUT ports; inputs are all known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_mode = 1'b0;
   logic [COORD_BITS-1:0]  req_first_x = '0, req_first_y = '0;
   logic [COORD_BITS-1:0]  req_second_x = '0, req_second_y = '0, req_line_y = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [PT_W-1:0] rsp_point_x, rsp_point_y;
   logic                   rsp_ok;
   logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0]      paddr = '0;
   logic [31:0]            pwdata = '0;
   logic [31:0]            prdata;
   logic                   pready;

   puck_rebound_predictor u_top (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_first_x, .req_first_y,
      .req_second_x, .req_second_y, .req_line_y,
      .rsp_valid, .rsp_ready, .rsp_point_x, .rsp_point_y, .rsp_ok,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #6 clock = ~clock;

   // ---------------- bench-side copy of the registers and stored line -------
   longint wall_lo = 0, wall_hi = 2047, center_col = 1024, inset = 10;
   longint bias_fx = 209715, max_rebounds = 3;
   longint track_slope = 0, track_icpt = 0;

   track_item_type pending_tracks[$];
   forecast_type   expected_forecasts[$];
   bit             failed = 0;
   bit             drv_busy = 0;

   function automatic longint clamp_bits(longint v, int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic forecast_type make_forecast(longint x, longint y, bit ok);
      forecast_type f;
      f.point_x = PT_W'(clamp_bits(x, PT_W));
      f.point_y = PT_W'(clamp_bits(y, PT_W));
      f.ok      = ok;
      return f;
   endfunction

   // Crossing prediction; updates the stored line exactly as the block does.
   function automatic forecast_type predict_crossing(track_item_type t);
      longint dx, dy, left, right, ly_fx, tx, a, b, x, bounces;
      if (t.mode) begin
         // wall-hit query on the integer-truncated stored line, no state change
         a = track_slope / ONE_FX;
         b = track_icpt / ONE_FX;
         if (a == 0) return make_forecast(0, 0, 1);
         x = (longint'(t.line_y) - b) / a;
         if (a < 0 && x < wall_lo) return make_forecast(wall_lo, a * wall_lo + b, 1);
         if (a > 0 && wall_hi < x) return make_forecast(wall_hi, a * wall_hi + b, 1);
         return make_forecast(x, longint'(t.line_y), 1);
      end
      dx    = longint'(t.second_x) - longint'(t.first_x);
      dy    = longint'(t.second_y) - longint'(t.first_y);
      left  = wall_lo + inset;
      right = wall_hi - inset;
      ly_fx = longint'(t.line_y) * ONE_FX;
      bounces = 0;
      // vertical, horizontal or flat motion: line cleared, centre fallback
      if (dx == 0 || dy == 0 || (dy * ONE_FX) / dx == 0) begin
         track_slope = 0;
         track_icpt  = 0;
         return make_forecast(center_col, longint'(t.line_y), 0);
      end
      track_slope = clamp_bits((dy * ONE_FX) / dx, SLOPE_W);
      track_icpt  = clamp_bits(longint'(t.second_y) * ONE_FX
                               - track_slope * longint'(t.second_x), ICPT_W);
      tx = (ly_fx - track_icpt) / track_slope;
      while (tx < left || right < tx) begin
         // mirror off the crossed wall, bias pushes the slope back inward
         if (tx < left) begin
            track_icpt  = clamp_bits(track_icpt + 2 * track_slope * left, ICPT_W);
            track_slope = clamp_bits(-track_slope + bias_fx, SLOPE_W);
         end else begin
            track_icpt  = clamp_bits(track_icpt + 2 * track_slope * right, ICPT_W);
            track_slope = clamp_bits(-track_slope - bias_fx, SLOPE_W);
         end
         bounces++;
         if (max_rebounds < bounces || track_slope == 0)
            return make_forecast(center_col, longint'(t.line_y), 0);
         tx = (ly_fx - track_icpt) / track_slope;
      end
      return make_forecast(tx, longint'(t.line_y), 1);
   endfunction

   // ---------------- request driver ----------------
   int             req_gap = 0;
   bit             req_no_idle = 0;
   track_item_type req_cur;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_forecasts.push_back(predict_crossing(req_cur));
            drv_busy = 0;
            if ($urandom_range(0, 63) == 0) req_no_idle = ~req_no_idle;
            req_gap = req_no_idle ? 0 : $urandom_range(0, 7);
         end
         if (!drv_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_tracks.size() > 0) begin
               req_cur      = pending_tracks.pop_front();
               drv_busy     = 1;
               req_mode     <= req_cur.mode;
               req_first_x  <= req_cur.first_x;
               req_first_y  <= req_cur.first_y;
               req_second_x <= req_cur.second_x;
               req_second_y <= req_cur.second_y;
               req_line_y   <= req_cur.line_y;
            end
         end
         req_valid <= drv_busy;
      end
   end

   // ---------------- result monitor ----------------
   int rsp_stall = 0;
   bit rsp_no_idle = 0;

   always @(posedge clock) begin
      forecast_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_forecasts.size() == 0) begin
               $display("%0t: unexpected result x=%0d y=%0d ok=%0b", $time,
                        rsp_point_x, rsp_point_y, rsp_ok);
               failed = 1;
            end else begin
               want = expected_forecasts.pop_front();
               if (rsp_point_x !== want.point_x) begin
                  $display("%0t: point_x expected %0d actual %0d", $time,
                           want.point_x, rsp_point_x);
                  failed = 1;
               end
               if (rsp_point_y !== want.point_y) begin
                  $display("%0t: point_y expected %0d actual %0d", $time,
                           want.point_y, rsp_point_y);
                  failed = 1;
               end
               if (rsp_ok !== want.ok) begin
                  $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_ok);
                  failed = 1;
               end
            end
            if ($urandom_range(0, 63) == 0) rsp_no_idle = ~rsp_no_idle;
            rsp_stall = rsp_no_idle ? 0 : $urandom_range(0, 7);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // ---------------- run limit ----------------
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   // register write: setup cycle, then access cycle; the model follows on the
   // edge that performs the write
   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_LEFT_WALL:  wall_lo      = longint'(value[COORD_BITS-1:0]);
         REG_RIGHT_WALL: wall_hi      = longint'(value[COORD_BITS-1:0]);
         REG_CENTER:     center_col   = longint'(value[COORD_BITS-1:0]);
         REG_MARGIN:     inset        = longint'(value[7:0]);
         REG_BIAS:       bias_fx      = longint'($signed(value[20:0]));
         REG_LIMIT:      max_rebounds = longint'(value[3:0]);
         default: ;
      endcase
   endtask

   task automatic apply_walls(int lo, int hi, int ctr, int ins, int bias, int lim);
      logic [20:0] bias_bits;
      bias_bits = bias[20:0];
      csr_write(REG_LEFT_WALL, lo);
      csr_write(REG_RIGHT_WALL, hi);
      csr_write(REG_CENTER, ctr);
      csr_write(REG_MARGIN, ins);
      csr_write(REG_BIAS, {11'd0, bias_bits});
      csr_write(REG_LIMIT, lim);
   endtask

   task automatic queue_track(bit m, int x1, int y1, int x2, int y2, int ly);
      track_item_type t;
      t.mode = m;
      t.first_x = COORD_BITS'(x1);  t.first_y = COORD_BITS'(y1);
      t.second_x = COORD_BITS'(x2); t.second_y = COORD_BITS'(y2);
      t.line_y = COORD_BITS'(ly);
      pending_tracks.push_back(t);
   endtask

   task automatic queue_random_tracks(int count);
      int x1, y1, x2, y2, kind;
      repeat (count) begin
         kind = $urandom_range(0, 99);
         x1 = $urandom_range(0, 2047);
         y1 = $urandom_range(0, 2047);
         x2 = $urandom_range(0, 2047);
         y2 = $urandom_range(0, 2047);
         if (kind < 4) x2 = x1;                      // vertical motion
         else if (kind < 8) y2 = y1;                 // horizontal motion
         else if (kind < 30) begin                   // short hop, typical tracking
            x2 = (x1 + $urandom_range(0, 64) - 32) & 11'h7ff;
            y2 = (y1 + $urandom_range(0, 64) - 32) & 11'h7ff;
         end
         queue_track(kind >= 80, x1, y1, x2, y2, $urandom_range(0, 2047));
      end
   endtask

   // wait until the block has drained; every item yields one result
   task automatic wait_drained();
      while (pending_tracks.size() > 0 || drv_busy || req_valid ||
             expected_forecasts.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   int lo_w, hi_w;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: default settings
      queue_track(1, 0, 0, 0, 0, 0);                    // stored line flat after reset
      queue_track(0, 100, 100, 200, 300, 500);          // plain crossing
      queue_track(1, 0, 0, 0, 0, 2047);
      queue_track(1, 2047, 2047, 2047, 2047, 0);
      queue_track(0, 500, 10, 500, 900, 700);           // vertical motion
      queue_track(0, 10, 500, 900, 500, 700);           // horizontal motion
      queue_track(0, 0, 0, 2047, 2047, 2047);
      queue_track(1, 0, 0, 0, 0, 1000);
      queue_track(0, 2047, 0, 0, 2047, 0);
      queue_track(0, 0, 2047, 2047, 0, 2047);
      queue_track(0, 100, 100, 105, 101, 0);            // bias cancels slope on bounce
      queue_track(0, 1000, 0, 1001, 2047, 1024);        // steep
      queue_track(0, 0, 1000, 2047, 1001, 0);           // shallow, too many bounces
      queue_track(1, 0, 0, 0, 0, 0);
      queue_track(0, 1000, 1000, 900, 1100, 2000);      // left bounce
      queue_track(1, 0, 0, 0, 0, 2047);
      queue_track(0, 1000, 1000, 1100, 1100, 2047);     // right bounce
      queue_track(1, 0, 0, 0, 0, 0);
      queue_track(0, 2047, 2047, 0, 0, 0);
      wait_drained();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: ;                                                      // reset values
            1: apply_walls(0, 2047, 0, 0, 0, 15);
            2: apply_walls(2047, 0, 2047, 255, -1048576, 0);          // crossed walls
            3: apply_walls(300, 1700, 1024, 255, 1048575, 15);
            default: begin
               lo_w = $urandom_range(0, 900);
               hi_w = $urandom_range(1100, 2047);
               if ($urandom_range(0, 5) == 0) begin
                  lo_w = $urandom_range(0, 2047);
                  hi_w = $urandom_range(0, 2047);
               end
               apply_walls(lo_w, hi_w, $urandom_range(0, 2047), $urandom_range(0, 255),
                           int'($urandom_range(0, 2097151)) - 1048576,
                           $urandom_range(0, 15));
            end
         endcase
         queue_random_tracks(RAND_ITEMS);
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (!failed)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/prp_pkg.sv
rtl/core/prp_div.sv
rtl/core/prp_csr.sv
rtl/core/puck_rebound_predictor.sv
bench/puck_rebound_predictor_test.sv
